@@ hdl/rde_pkg.sv @@
// Package for the radix digit emitter: widths, defaults, constants and the ASCII map.
`timescale 1ns / 1ps
package rde_pkg;

  localparam int ValueW       = 32;
  localparam int RadixW       = 5;
  localparam int CharW        = 7;
  localparam int DigitW       = 4;
  localparam int ValueBitsDef = 32;
  localparam int MaxDigitsDef = 32;
  localparam int ChunkBits    = 8;

  localparam logic [RadixW-1:0] RadixReset = 5'd16;
  localparam logic [RadixW-1:0] BaseMin    = 5'd2;
  localparam logic [RadixW-1:0] BaseMax    = 5'd16;
  localparam logic [DigitW-1:0] DecBase    = 4'd10;
  localparam logic [CharW-1:0]  AsciiZero  = 7'd48;
  localparam logic [CharW-1:0]  AsciiA     = 7'd65;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StRd,
    StEmit
  } state_e;

  function automatic logic [CharW-1:0] ascii_of(input logic [DigitW-1:0] d);
    logic [CharW-1:0] c;
    if (d < DecBase) begin
      c = AsciiZero + CharW'(d);
    end else begin
      c = AsciiA + CharW'(d - DecBase);
    end
    return c;
  endfunction

endpackage

@@ hdl/radix_digit_emitter.sv @@
// Top level: converts an unsigned word to base 2..16 digits, emitted MSB first as ASCII.
// One shared divide unit retires 8 dividend bits a cycle, working through every chunk of the word
//   for each digit; the digits are then read back through the digit RAM and emitted as the output takes them.
// One word at a time; a zero word yields no digits and the block is ready the next cycle.
// Reset (async, active low): radix 16, digit count 0, idle; digit RAM is not cleared.
`timescale 1ns / 1ps
module radix_digit_emitter #(
  parameter int VALUE_BITS = rde_pkg::ValueBitsDef,
  parameter int MAX_DIGITS = rde_pkg::MaxDigitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rde_pkg::RadixW-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [rde_pkg::ValueW-1:0]  value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rde_pkg::CharW-1:0]   digit_char_o,
  output logic [rde_pkg::DigitW-1:0]  digit_value_o,
  output logic                        last_digit_o
);
  import rde_pkg::*;

  localparam int Chunks = (VALUE_BITS + ChunkBits - 1) / ChunkBits;
  localparam int DivW   = Chunks * ChunkBits;
  localparam int ChunkW = (Chunks > 1) ? $clog2(Chunks) : 1;
  localparam int AddrW  = $clog2(MAX_DIGITS);
  localparam int CountW = $clog2(MAX_DIGITS + 1);
  localparam logic [DivW-1:0] VMask = {DivW{1'b1}} >> (DivW - VALUE_BITS);

  state_e state_q, state_d;
  logic [RadixW-1:0] radix_q;
  logic [RadixW-1:0] base;
  logic [DivW-1:0]   v_q, v_d;
  logic [DigitW-1:0] rem_q, rem_d;
  logic [ChunkW-1:0] chunk_q, chunk_d;
  logic [CountW-1:0] n_q, n_d;
  logic [AddrW-1:0]  rd_q, rd_d;
  logic              out_valid_q, out_valid_d;
  logic [CharW-1:0]  char_q, char_d;
  logic [DigitW-1:0] dval_q, dval_d;
  logic              last_q, last_d;

  logic [DivW+ValueW-1:0] ext;
  logic [DivW-1:0]        v_load;
  logic [DivW+ChunkBits-1:0] shifted;
  logic [ChunkBits-1:0]   qbyte;
  logic [DigitW-1:0]      rem_next;
  logic [DigitW:0]        trial;
  logic                   we;
  logic [DigitW-1:0]      rdata;

  assign ext    = {DivW'(0), value_i};
  assign v_load = ext[DivW-1:0] & VMask;

  always_comb begin
    if (radix_q inside {[BaseMin:BaseMax]}) begin
      base = radix_q;
    end else if (radix_q < BaseMin) begin
      base = BaseMin;
    end else begin
      base = BaseMax;
    end
  end

  // 8 restoring steps on the narrow remainder
  always_comb begin
    rem_next = rem_q;
    qbyte    = '0;
    trial    = '0;
    for (int i = 0; i < ChunkBits; i++) begin
      trial = {rem_next, v_q[DivW-1-i]};
      if (trial >= base) begin
        trial = trial - base;
        qbyte[ChunkBits-1-i] = 1'b1;
      end
      rem_next = trial[DigitW-1:0];
    end
    shifted = {v_q, qbyte};
  end

  always_comb begin
    state_d     = state_q;
    v_d         = v_q;
    rem_d       = rem_q;
    chunk_d     = chunk_q;
    n_d         = n_q;
    rd_d        = rd_q;
    out_valid_d = out_valid_q && out_stall_i;
    char_d      = char_q;
    dval_d      = dval_q;
    last_d      = last_q;
    we          = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          v_d     = v_load;
          rem_d   = '0;
          chunk_d = '0;
          n_d     = '0;
          if (v_load != '0) begin
            state_d = StDiv;
          end
        end
      end
      StDiv: begin
        v_d   = shifted[DivW-1:0];
        rem_d = rem_next;
        if (chunk_q == ChunkW'(Chunks - 1)) begin
          we      = 1'b1;
          rem_d   = '0;
          chunk_d = '0;
          n_d     = n_q + 1'b1;
          rd_d    = n_q[AddrW-1:0];
          if (shifted[DivW-1:0] == '0 || n_q == CountW'(MAX_DIGITS - 1)) begin
            state_d = StRd;
          end
        end else begin
          chunk_d = chunk_q + 1'b1;
        end
      end
      StRd: begin
        state_d = StEmit;
      end
      StEmit: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          char_d      = ascii_of(rdata);
          dval_d      = rdata;
          last_d      = (rd_q == '0);
          if (rd_q == '0) begin
            state_d = StIdle;
          end else begin
            rd_d    = rd_q - 1'b1;
            state_d = StRd;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      radix_q     <= RadixReset;
      n_q         <= '0;
      chunk_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      chunk_q     <= chunk_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        radix_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    rem_q  <= rem_d;
    rd_q   <= rd_d;
    char_q <= char_d;
    dval_q <= dval_d;
    last_q <= last_d;
  end

  rde_ram #(
    .Width (DigitW),
    .Depth (MAX_DIGITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (n_q[AddrW-1:0]),
    .wdata_i (rem_next),
    .raddr_i (rd_q),
    .rdata_o (rdata)
  );

  assign cfg_ready_o   = 1'b1;
  assign in_stall_o    = (state_q != StIdle);
  assign out_valid_o   = out_valid_q;
  assign digit_char_o  = char_q;
  assign digit_value_o = dval_q;
  assign last_digit_o  = last_q;

endmodule

@@ hdl/rde_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rde_ram #(
  parameter int Width = 4,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/rde_checker.sv @@
// Port-level checks for the radix digit emitter, bound to the top level.
`timescale 1ns / 1ps
module rde_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_o,
  input logic [rde_pkg::RadixW-1:0]  cfg_data_i,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [rde_pkg::ValueW-1:0]  value_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [rde_pkg::CharW-1:0]   digit_char_o,
  input logic [rde_pkg::DigitW-1:0]  digit_value_o,
  input logic                        last_digit_o
);
  import rde_pkg::*;

  logic unused_cfg;
  assign unused_cfg = cfg_valid_i & cfg_ready_o & (^cfg_data_i);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(digit_char_o)
      && $stable(digit_value_o) && $stable(last_digit_o))
    else $error("stalled output word changed");

  a_char_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> digit_char_o == ascii_of(digit_value_o))
    else $error("digit char does not match digit value");

  a_busy_after_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && value_i != '0 |=> in_stall_o)
    else $error("not busy after nonzero word");

  a_idle_after_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && value_i == '0 |=> !in_stall_o)
    else $error("zero word made the block busy");

endmodule

bind radix_digit_emitter rde_checker u_rde_checker (.*);

@@ bench/tb.sv @@
// Self-checking bench for radix_digit_emitter: radix settings, random words and idle patterns.
`timescale 1ns / 1ps
module tb;
  import rde_pkg::*;

  typedef struct packed {
    logic [CharW-1:0]  ch;
    logic [DigitW-1:0] val;
    logic              last;
  } digit_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [RadixW-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [ValueW-1:0] value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CharW-1:0]  digit_char;
  logic [DigitW-1:0] digit_value;
  logic              last_digit;

  logic [ValueW-1:0] word_q[$];
  digit_t            digit_q[$];
  logic [RadixW-1:0] radix_cfg = RadixReset;
  bit                in_fire;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_stall_pct = 0;
  int                fail_count = 0;

  radix_digit_emitter uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .value_i      (value),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .digit_char_o (digit_char),
    .digit_value_o(digit_value),
    .last_digit_o (last_digit)
  );

  always #10 clk = ~clk;

  // expected digits of one word, most significant first
  function automatic void expand_digits(input logic [ValueW-1:0] word);
    logic [DigitW-1:0] rem[MaxDigitsDef];
    logic [ValueW-1:0] v;
    int unsigned       b;
    int                n;
    digit_t            d;
    b = (radix_cfg < BaseMin) ? BaseMin : (radix_cfg > BaseMax) ? BaseMax : radix_cfg;
    v = word;
    n = 0;
    while (v != 0 && n < MaxDigitsDef) begin
      rem[n] = DigitW'(v % b);
      v = v / b;
      n++;
    end
    for (int k = n - 1; k >= 0; k--) begin
      d.val = rem[k];
      d.ch = (rem[k] < DecBase) ? AsciiZero + CharW'(rem[k])
                                : AsciiA + CharW'(rem[k] - DecBase);
      d.last = (k == 0);
      digit_q.push_back(d);
    end
  endfunction

  function automatic logic [ValueW-1:0] pick_word();
    logic [ValueW-1:0] w;
    case ($urandom_range(0, 5))
      0: w = $urandom;
      1: w = $urandom >> $urandom_range(0, 31);
      2: w = $urandom_range(0, 40);
      3: w = 32'hFFFF_FFFF >> $urandom_range(0, 31);
      4: w = 32'h1 << $urandom_range(0, 31);
      default: w = $urandom | 32'h8000_0000;
    endcase
    return w;
  endfunction

  // word driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (word_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        value <= word_q.pop_front();
      end else begin
        in_valid <= 1'b0;
        value <= $urandom;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // monitor: predict on accepted words, check accepted digits
  always @(posedge clk) begin
    digit_t want;
    in_fire = rst_n && in_valid && !in_stall;
    if (in_fire) expand_digits(value);
    if (rst_n && out_valid && !out_stall) begin
      if (digit_q.size() == 0) begin
        $error("unexpected digit: char %0d value %0d last %0d",
               digit_char, digit_value, last_digit);
        fail_count++;
      end else begin
        want = digit_q.pop_front();
        if (digit_char !== want.ch) begin
          $error("digit_char: expected %0d, got %0d", want.ch, digit_char);
          fail_count++;
        end
        if (digit_value !== want.val) begin
          $error("digit_value: expected %0d, got %0d", want.val, digit_value);
          fail_count++;
        end
        if (last_digit !== want.last) begin
          $error("last_digit: expected %0d, got %0d", want.last, last_digit);
          fail_count++;
        end
      end
    end
  end

  task automatic drain();
    while (word_q.size() != 0 || in_valid || digit_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_radix(input logic [RadixW-1:0] r);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= r;
    do @(posedge clk); while (!cfg_ready);
    radix_cfg = r;
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data <= RadixW'($urandom);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
      default: begin send_idle_pct = 32; recv_stall_pct = 32; end
    endcase
  endtask

  initial begin
    logic [RadixW-1:0] phase_radix[8];
    phase_radix = '{5'd2, 5'd16, 5'd10, 5'd3, 5'd1, 5'd17, 5'd7, 5'd0};
    phase_radix[7] = RadixW'($urandom_range(0, 31));
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset radix, then saturating and decimal settings
    set_idling(3);
    word_q = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd15, 32'd16, 32'h8000_0000,
               32'hFEDC_BA98, 32'h0123_4567};
    drain();
    write_radix(5'd0);
    word_q = '{32'd1, 32'd2, 32'hFFFF_FFFF, 32'h8000_0000};
    drain();
    write_radix(5'd31);
    word_q = '{32'hDEAD_BEEF, 32'd0};
    drain();
    write_radix(5'd10);
    word_q = '{32'd9, 32'd10, 32'd1_000_000_000, 32'hFFFF_FFFF};
    drain();

    for (int p = 0; p < 8; p++) begin
      write_radix(phase_radix[p]);
      set_idling(p % 4);
      for (int i = 0; i < 16; i++) word_q.push_back(pick_word());
      drain();
      for (int i = 0; i < 16; i++) word_q.push_back(pick_word());
      drain();
    end

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ files.f @@
hdl/rde_pkg.sv
hdl/rde_ram.sv
hdl/radix_digit_emitter.sv
hdl/rde_checker.sv
bench/tb.sv
